/* rtl/mgdw_pkg.sv */
// shared constants, codes and controller/datapath interface types of the dfs walker
`default_nettype none

package mgdw_pkg;

	// graph and stack sizing
	localparam int MAX_VERTICES = 32;
	localparam int STACK_DEPTH  = 1024;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 6;
	localparam int STK_AW       = $clog2(STACK_DEPTH);
	localparam int STK_DW       = $clog2(STACK_DEPTH + 1);

	// stream word widths
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 8;

	// operation codes carried on the input tuser
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_WALK    = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;   // set both bits of an edge
		logic start;    // clear marks, push start vertex
		logic pop;      // read top of stack, decrement depth
		logic visit;    // mark popped vertex, begin row scan
		logic advance;  // pending result to output, new vertex to pending
		logic scan;     // test one neighbor, push it if unvisited
		logic flush;    // pending result to output flagged last
	} mgdw_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic walk_op;      // input word is a walk
		logic start_ok;     // start vertex is in range
		logic stack_empty;  // no entry left on the stack
		logic fresh;        // popped vertex is in range and unvisited
		logic scan_last;    // scan index reached vertex 0
		logic pend_valid;   // a result waits in the pending slot
		logic out_free;     // output register can take a word
	} mgdw_stat_t;

endpackage

`default_nettype wire

/* rtl/matrix_graph_dfs_walker.sv */
// Top level of the adjacency-matrix depth-first walker.
// Insert word, or walk word with its start out of range: taken in IDLE, no output word.
// Walk word: taken, then each stack pop goes through a registered stack read, each newly
// visited vertex is emitted and its row scanned one neighbor per cycle, and the last result
// is flushed at the end; a stalled output holds the walk in the emit and finish states.
// Reset clears the matrix, marks and stack depth and sets the vertex count to 32; no clearing pass.
`default_nettype none

module matrix_graph_dfs_walker
	import mgdw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// vertex count register
	input  wire logic                  cfg_we,
	input  wire logic [CNT_W-1:0]      cfg_wdata,
	// input words
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // vertex_a[4:0], vertex_b[9:5], zero fill
	input  wire logic                  s_axis_tuser,   // op
	// result words
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // visited_vertex[4:0], zero fill
	output logic                       m_axis_tlast    // last
);

	mgdw_cmd_t  cmd;
	mgdw_stat_t stat;

	// sequencing
	mgdw_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// storage and result path
	mgdw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

`default_nettype wire

/* rtl/mgdw_datapath.sv */
// datapath of the dfs walker: adjacency matrix, visited marks, stack memory, result registers
`default_nettype none

module mgdw_datapath
	import mgdw_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CNT_W-1:0]      cfg_wdata,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                  s_axis_tuser,
	input  wire logic                  m_axis_tready,
	output logic                       m_axis_tvalid,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast,
	input  wire mgdw_cmd_t             cmd,
	output mgdw_stat_t                 stat
);

	logic [CNT_W-1:0]        vertex_count_q;
	logic [CNT_W-1:0]        n_active;
	logic [VTX_W-1:0]        in_a;
	logic [VTX_W-1:0]        in_b;
	logic [MAX_VERTICES-1:0] onehot_a;
	logic [MAX_VERTICES-1:0] onehot_b;
	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] visited_q;
	logic [VTX_W-1:0]        stack_mem [STACK_DEPTH];
	logic [VTX_W-1:0]        stack_rd_q;
	logic [STK_DW-1:0]       depth_q;
	logic [STK_DW-1:0]       depth_dec;
	logic [VTX_W-1:0]        cur_u_q;
	logic [VTX_W-1:0]        scan_w_q;
	logic                    push_hit;
	logic                    stack_full;
	logic                    pend_valid_q;
	logic [VTX_W-1:0]        pend_vertex_q;
	logic                    out_valid_q;
	logic [VTX_W-1:0]        out_vertex_q;
	logic                    out_last_q;
	logic                    out_free;

	// input word fields
	assign in_a = s_axis_tdata[VTX_W-1:0];
	assign in_b = s_axis_tdata[2*VTX_W-1:VTX_W];

	// one-hot column masks of the two endpoints
	assign onehot_a = MAX_VERTICES'(1) << in_a;
	assign onehot_b = MAX_VERTICES'(1) << in_b;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CNT_W'(MAX_VERTICES);
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// number of vertices in use, saturated to the matrix size
	assign n_active = (vertex_count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
	                                                          : vertex_count_q;

	// adjacency matrix, cleared at reset; row a gets bit b and row b gets bit a
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.insert && ({1'b0, in_a} < n_active) && ({1'b0, in_b} < n_active)) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				adj_q[i] <= adj_q[i] | ((VTX_W'(i) == in_a) ? onehot_b : '0)
				                     | ((VTX_W'(i) == in_b) ? onehot_a : '0);
			end
		end
	end

	// neighbor test at the scan index
	assign push_hit   = adj_q[cur_u_q][scan_w_q] && !visited_q[scan_w_q];
	assign stack_full = (depth_q >= STK_DW'(STACK_DEPTH));
	assign depth_dec  = depth_q - 1'b1;

	// visited marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
		end else if (cmd.start) begin
			visited_q <= '0;
		end else if (cmd.visit) begin
			visited_q[stack_rd_q] <= 1'b1;
		end
	end

	// stack depth, current vertex and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			cur_u_q  <= '0;
			scan_w_q <= '0;
		end else begin
			if (cmd.start) begin
				depth_q <= STK_DW'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_dec;
			end else if (cmd.scan && push_hit && !stack_full) begin
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.visit) begin
				cur_u_q  <= stack_rd_q;
				scan_w_q <= VTX_W'(n_active - 1'b1);
			end else if (cmd.scan) begin
				scan_w_q <= scan_w_q - 1'b1;
			end
		end
	end

	// stack memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stack_mem[STK_AW'(0)] <= in_a;
		end else if (cmd.scan && push_hit && !stack_full) begin
			stack_mem[depth_q[STK_AW-1:0]] <= scan_w_q;
		end
		if (cmd.pop) begin
			stack_rd_q <= stack_mem[depth_dec[STK_AW-1:0]];
		end
	end

	// pending result and output register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.advance) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if ((cmd.advance && pend_valid_q) || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of pending and output words
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			pend_vertex_q <= cur_u_q;
		end
		if ((cmd.advance && pend_valid_q) || cmd.flush) begin
			out_vertex_q <= pend_vertex_q;
			out_last_q   <= cmd.flush;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_vertex_q);
	assign m_axis_tlast  = out_last_q;

	// status to the controller
	always_comb begin
		stat.walk_op     = (s_axis_tuser == OP_WALK);
		stat.start_ok    = ({1'b0, in_a} < n_active);
		stat.stack_empty = (depth_q == '0);
		stat.fresh       = ({1'b0, stack_rd_q} < n_active) && !visited_q[stack_rd_q];
		stat.scan_last   = (scan_w_q == '0);
		stat.pend_valid  = pend_valid_q;
		stat.out_free    = out_free;
	end

endmodule

`default_nettype wire

/* rtl/mgdw_ctrl.sv */
// controller state machine of the dfs walker
`default_nettype none

module mgdw_ctrl
	import mgdw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire mgdw_stat_t stat,
	output mgdw_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK,
		ST_EMIT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   in_acc;
	logic   emit_go;
	logic   flush_go;

	assign s_axis_tready = ready_q;
	assign in_acc        = s_axis_tvalid && ready_q;
	assign emit_go       = !stat.pend_valid || stat.out_free;
	assign flush_go      = stat.pend_valid && stat.out_free;

	// commands decoded from state and status
	always_comb begin
		cmd         = '0;
		cmd.insert  = (state_q == ST_IDLE) && in_acc && !stat.walk_op;
		cmd.start   = (state_q == ST_IDLE) && in_acc && stat.walk_op && stat.start_ok;
		cmd.pop     = (state_q == ST_POP) && !stat.stack_empty;
		cmd.visit   = (state_q == ST_CHECK) && stat.fresh;
		cmd.advance = (state_q == ST_EMIT) && emit_go;
		cmd.scan    = (state_q == ST_SCAN);
		cmd.flush   = (state_q == ST_FINISH) && flush_go;
	end

	// state and input ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_POP;
						ready_q <= 1'b0;
					end
				end
				ST_POP: begin
					state_q <= stat.stack_empty ? ST_FINISH : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= stat.fresh ? ST_EMIT : ST_POP;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_POP;
					end
				end
				ST_FINISH: begin
					if (!stat.pend_valid || stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/mgdw_checker.sv */
// port-level checker of the dfs walker and its bind to the top level
`default_nettype none

module mgdw_checker
	import mgdw_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tlast
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// no result word while in reset
	assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result word valid during reset");

	// fill bits above the vertex stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:VTX_W] == '0))
		else $error("result fill bits not zero");

	// an idle block with an empty output does not produce a word next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result word appeared from idle");

endmodule

bind matrix_graph_dfs_walker mgdw_checker u_mgdw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
